/* design/lowest_free_handle_table_unit_defines.svh */
// Assertion macros used by the handle table RTL.
`ifndef LOWEST_FREE_HANDLE_TABLE_UNIT_DEFINES_SVH
`define LOWEST_FREE_HANDLE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LFHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lfht_pkg.sv */
// Types, constants and codes of the lowest-free handle table.
`default_nettype none

package lfht_pkg;

  // Table geometry
  localparam int SLOTS     = 64;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);

  // Fixed field widths of the item channels
  localparam int ACT_W  = 2;
  localparam int SLOT_W = 6;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 7;

  // Action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_GET    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  // Input item
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] payload;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
    logic [DATA_W-1:0] payload_out;
    logic [OCC_W-1:0]  occupied;
  } out_item_t;

  // Request from the sequencer to the allocator
  typedef struct packed {
    logic             en;
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             word_nz;
  } alloc_req_t;

  // Decision returned by the allocator
  typedef struct packed {
    logic              ok;
    logic              wr;
    logic              rd;
    logic              rm;
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0]  free_idx;
  } alloc_dec_t;

endpackage

`default_nettype wire

/* design/lfht_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module lfht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/lfht_alloc.sv */
// Occupancy bitmap, lowest-free search and occupied-slot count.
`default_nettype none

module lfht_alloc import lfht_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire alloc_req_t req,
  output alloc_dec_t      dec,
  output logic [CNT_W-1:0] count_r
);

  logic [SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic [IDX_W-1:0] free_idx;
  logic             full;

  // Priority encoder: lowest clear bit of the bitmap
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign full = (count_r == CNT_W'(SLOTS));

  // Per-action decision
  always_comb begin
    dec          = '0;
    dec.free_idx = free_idx;
    case (req.action)
      ACT_ADD: begin
        if (req.word_nz && !full) begin
          dec.ok   = 1'b1;
          dec.wr   = 1'b1;
          dec.slot = SLOT_W'(free_idx);
        end else begin
          dec.slot = SLOT_W'(req.idx);
        end
      end
      ACT_GET: begin
        dec.slot = SLOT_W'(req.idx);
        if (req.in_range && slot_valid_r[req.idx]) begin
          dec.ok = 1'b1;
          dec.rd = 1'b1;
        end
      end
      ACT_REMOVE: begin
        dec.slot = SLOT_W'(req.idx);
        if (req.in_range && slot_valid_r[req.idx]) begin
          dec.ok = 1'b1;
          dec.rm = 1'b1;
        end
      end
      default: begin
        dec.slot = SLOT_W'(req.idx);
      end
    endcase
  end

  // Bitmap and count update
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    count_nxt      = count_r;
    if (req.en && dec.wr) begin
      slot_valid_nxt[free_idx] = 1'b1;
      count_nxt                = count_r + CNT_W'(1);
    end else if (req.en && dec.rm) begin
      slot_valid_nxt[req.idx] = 1'b0;
      count_nxt               = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      count_r      <= '0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/lowest_free_handle_table_unit.sv */
// Lowest-free handle table: add, get and remove over a slot store.
// An accepted item is decided and its RAM access issued on acceptance; the result register
// loads in the response state, from the decision stage and the returned RAM read data.
// An item may be accepted while the previous result waits; its own result loads, and the
// next item is taken, only once the output register is free. Reset clears the bitmap,
// the count and the handshakes; the word RAM is not cleared, as only occupied slots are read.
`default_nettype none

module lowest_free_handle_table_unit import lfht_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

`include "lowest_free_handle_table_unit_defines.svh"

  state_t            state_r, state_nxt;
  logic              accept;
  logic              load_out;
  alloc_req_t        req;
  alloc_dec_t        dec;
  logic [CNT_W-1:0]  count;
  logic [WORD_BITS-1:0] rdata;
  logic              ram_we, ram_re;

  // Decision held for the response cycle
  logic              ok_r, get_r;
  logic [SLOT_W-1:0] slot_r;

  // Output register
  logic              out_valid_r;
  out_item_t         out_item_r, out_item_nxt;

  assign accept = in_valid && in_ready;

  // Request to the allocator
  always_comb begin
    req          = '0;
    req.en       = accept;
    req.action   = in_item.action;
    req.idx      = IDX_W'(in_item.slot);
    req.in_range = (CNT_W'(in_item.slot) < CNT_W'(SLOTS));
    req.word_nz  = (in_item.payload[WORD_BITS-1:0] != '0);
  end

  lfht_alloc u_alloc (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .dec     (dec),
    .count_r (count)
  );

  // Word store: write on successful add, read on successful get
  assign ram_we = accept && dec.wr;
  assign ram_re = accept && dec.rd;

  lfht_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (dec.free_idx),
    .wdata   (in_item.payload[WORD_BITS-1:0]),
    .re      (ram_re),
    .raddr   (req.idx),
    .rdata_r (rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_RESP: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decision stage
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r   <= dec.ok;
      get_r  <= dec.rd;
      slot_r <= dec.slot;
    end
  end

  // Result assembly; count is already updated by the accepted item
  always_comb begin
    out_item_nxt             = '0;
    out_item_nxt.ok          = ok_r;
    out_item_nxt.slot_out    = slot_r;
    out_item_nxt.payload_out = get_r ? DATA_W'(rdata) : '0;
    out_item_nxt.occupied    = OCC_W'(count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  `LFHT_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(SLOTS), "occupied count above table size")
  `LFHT_ASSERT_NOW(a_ram_excl, 1'b1, !(ram_we && ram_re), "word store written and read together")
  `LFHT_ASSERT_NEXT(a_accept_resp, accept, state_r == ST_RESP, "accepted item did not reach response")
  `LFHT_ASSERT_NOW(a_data_ok, out_valid_r && (out_item_r.payload_out != '0), out_item_r.ok, "data returned on a failed result")

endmodule

`default_nettype wire
